// ===== rtl/mse_pkg.sv =====
// Package for the MIPS subset execute block.
// Holds opcode and function codes, field widths and shared constants.
// No dependencies.
package mse_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned REG_AW = 5;

   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
   localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;
   localparam logic [4:0] LINK_REG = 5'd31;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J = 6'h02;
   localparam logic [5:0] OP_JAL = 6'h03;
   localparam logic [5:0] OP_BEQ = 6'h04;
   localparam logic [5:0] OP_BNE = 6'h05;
   localparam logic [5:0] OP_ADDI = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI = 6'h0A;
   localparam logic [5:0] OP_SLTIU = 6'h0B;
   localparam logic [5:0] OP_ANDI = 6'h0C;
   localparam logic [5:0] OP_ORI = 6'h0D;
   localparam logic [5:0] OP_LUI = 6'h0F;
   localparam logic [5:0] OP_LW = 6'h23;
   localparam logic [5:0] OP_LBU = 6'h24;
   localparam logic [5:0] OP_LHU = 6'h25;
   localparam logic [5:0] OP_SW = 6'h2B;

   localparam logic [5:0] FN_SLL = 6'h00;
   localparam logic [5:0] FN_SRL = 6'h02;
   localparam logic [5:0] FN_SRA = 6'h03;
   localparam logic [5:0] FN_JR = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV = 6'h1A;
   localparam logic [5:0] FN_DIVU = 6'h1B;
   localparam logic [5:0] FN_ADD = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND = 6'h24;
   localparam logic [5:0] FN_OR = 6'h25;
   localparam logic [5:0] FN_NOR = 6'h27;
   localparam logic [5:0] FN_SLT = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   typedef logic [XLEN-1:0] word_type;

endpackage

// ===== rtl/mse_if.sv =====
// Handshake interfaces for the MIPS subset execute block.
// Depends on mse_pkg for the word type.
interface mse_req_if;
   logic valid;
   logic ready;
   mse_pkg::word_type instruction;
   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface mse_rsp_if;
   logic valid;
   logic ready;
   mse_pkg::word_type next_pc;
   logic [4:0] dest_reg;
   mse_pkg::word_type dest_value;
   logic mem_write;
   logic halted;
   modport source (output valid, output next_pc, output dest_reg, output dest_value,
                   output mem_write, output halted, input ready);
   modport sink (input valid, input next_pc, input dest_reg, input dest_value,
                 input mem_write, input halted, output ready);
endinterface

// ===== rtl/mips_subset_execute.sv =====
// Top level of the MIPS subset execute block: sequencer, register file,
// data memory and the shared iterative multiply and divide unit.
// Depends on mse_pkg and on the interfaces in mse_if.sv.
//
// Each transaction on req_chan carries one instruction word; each produces
// exactly one transaction on rsp_chan with the next pc, the register written,
// its value, a store flag and the halt flag. One instruction is in flight at a
// time, and req_chan.ready is low from acceptance until the cycle after the
// response is taken. rsp_chan.valid rises after the states S_READ, S_EXEC and
// S_WB for ALU, branch, jump and store instructions, and loads add S_MEM after
// S_EXEC; S_READ takes the registered read of the register file and S_MEM the
// registered read of the data memory. Multiply and divide pass through S_ITER,
// where the iterative unit runs 32 iterations, then S_FIX, which fixes the
// signs. A divide by zero skips the iterations. The response stays in its
// output registers while rsp_chan.ready is low, and nothing else advances.
// After reset the block clears the data memory, one word per cycle, all
// MEM_WORDS words, before it accepts its first instruction. The register file
// clears at once through its valid bits. MEM_WORDS must be a power of two.
module mips_subset_execute #(
   parameter int unsigned MEM_WORDS = 1024
) (
   input logic clock,
   input logic reset,
   mse_req_if.sink req_chan,
   mse_rsp_if.source rsp_chan
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MEM, S_ITER, S_FIX, S_WB
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [31:0] ins_ff;
   logic [31:0] pc_ff, hi_ff, lo_ff;
   logic halt_ff;
   logic [31:0] rf_vld_ff;
   logic [31:0] rf [32];
   logic [31:0] rf_a_ff, rf_b_ff;
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_rd_ff;
   logic [31:0] npc_ff, wr_val_ff, addr_ff;
   logic [4:0] wr_reg_ff;
   logic memw_ff;
   logic [31:0] acc_hi_ff, acc_lo_ff, opnd_ff;
   logic [4:0] iter_ff;
   logic is_div_ff, neg_q_ff, neg_r_ff;
   logic rsp_valid_ff;
   logic [31:0] rsp_npc_ff, rsp_val_ff;
   logic [4:0] rsp_reg_ff;
   logic rsp_memw_ff, rsp_halt_ff;

   logic [5:0] op, fn;
   logic [4:0] rs, rt, rd, sh;
   logic [31:0] zimm, simm, vs, vt, pc4;
   logic [31:0] ex_npc, ex_val, ex_addr;
   logic [4:0] ex_reg;
   logic ex_halt, ex_load, ex_store, ex_md, ex_div, ex_sgn, ex_divzero;
   logic [31:0] ma, mb;
   logic [32:0] mul_sum, div_t, div_d;
   logic div_ge;
   logic [63:0] prod_fix;
   logic [31:0] ld_val;
   logic [AW-1:0] ex_idx;

   assign op = ins_ff[31:26];
   assign rs = ins_ff[25:21];
   assign rt = ins_ff[20:16];
   assign rd = ins_ff[15:11];
   assign sh = ins_ff[10:6];
   assign fn = ins_ff[5:0];
   assign zimm = {16'h0000, ins_ff[15:0]};
   assign simm = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign vs = rf_vld_ff[rs] ? rf_a_ff : 32'h0;
   assign vt = rf_vld_ff[rt] ? rf_b_ff : 32'h0;
   assign pc4 = pc_ff + 32'd4;
   assign ex_addr = vs + simm;
   assign ex_idx = ex_addr[AW+1:2];

   always_comb begin
      ex_npc = pc4;
      ex_reg = 5'd0;
      ex_val = 32'h0;
      ex_halt = 1'b0;
      ex_load = 1'b0;
      ex_store = 1'b0;
      ex_md = 1'b0;
      ex_div = 1'b0;
      ex_sgn = 1'b0;
      if (halt_ff || ins_ff == mse_pkg::HALT_WORD) begin
         ex_halt = 1'b1;
         ex_npc = pc_ff;
      end else if (op == mse_pkg::OP_SPECIAL) begin
         ex_reg = rd;
         case (fn)
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: ex_val = vs + vt;
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: ex_val = vs - vt;
            mse_pkg::FN_AND: ex_val = vs & vt;
            mse_pkg::FN_OR: ex_val = vs | vt;
            mse_pkg::FN_NOR: ex_val = ~(vs | vt);
            mse_pkg::FN_SLT: ex_val = {31'h0, $signed(vs) < $signed(vt)};
            mse_pkg::FN_SLTU: ex_val = {31'h0, vs < vt};
            mse_pkg::FN_SLL: ex_val = vt << sh;
            mse_pkg::FN_SRL: ex_val = vt >> sh;
            mse_pkg::FN_SRA: ex_val = 32'($signed(vt) >>> sh);
            mse_pkg::FN_MFHI: ex_val = hi_ff;
            mse_pkg::FN_MFLO: ex_val = lo_ff;
            mse_pkg::FN_JR: begin
               ex_reg = 5'd0;
               ex_npc = vs;
            end
            mse_pkg::FN_MULT, mse_pkg::FN_MULTU, mse_pkg::FN_DIV, mse_pkg::FN_DIVU: begin
               ex_reg = 5'd0;
               ex_md = 1'b1;
               ex_div = fn[1];
               ex_sgn = ~fn[0];
            end
            default: ex_reg = 5'd0;
         endcase
      end else begin
         ex_reg = rt;
         case (op)
            mse_pkg::OP_J, mse_pkg::OP_JAL: begin
               ex_reg = op[0] ? mse_pkg::LINK_REG : 5'd0;
               ex_val = pc_ff + 32'd8;
               ex_npc = (pc4 & mse_pkg::JUMP_REGION_MASK) | {4'h0, ins_ff[25:0], 2'b00};
            end
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: ex_val = vs + simm;
            mse_pkg::OP_ANDI: ex_val = vs & zimm;
            mse_pkg::OP_ORI: ex_val = vs | zimm;
            mse_pkg::OP_SLTI: ex_val = {31'h0, $signed(vs) < $signed(simm)};
            mse_pkg::OP_SLTIU: ex_val = {31'h0, vs < simm};
            mse_pkg::OP_LUI: ex_val = {ins_ff[15:0], 16'h0000};
            mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
               ex_reg = 5'd0;
               if ((vs == vt) != op[0]) begin
                  ex_npc = pc4 + {simm[29:0], 2'b00};
               end
            end
            mse_pkg::OP_LW, mse_pkg::OP_LBU, mse_pkg::OP_LHU: ex_load = 1'b1;
            mse_pkg::OP_SW: begin
               ex_reg = 5'd0;
               ex_store = 1'b1;
            end
            default: ex_reg = 5'd0;
         endcase
      end
   end

   assign ex_divzero = ex_div && vt == 32'h0;
   assign ma = (ex_sgn && vs[31]) ? -vs : vs;
   assign mb = (ex_sgn && vt[31]) ? -vt : vt;

   assign mul_sum = {1'b0, acc_hi_ff} + (acc_lo_ff[0] ? {1'b0, opnd_ff} : 33'h0);
   assign div_t = {acc_hi_ff, acc_lo_ff[31]};
   assign div_d = div_t - {1'b0, opnd_ff};
   assign div_ge = ~div_d[32];
   assign prod_fix = neg_q_ff ? -{acc_hi_ff, acc_lo_ff} : {acc_hi_ff, acc_lo_ff};

   always_comb begin
      case (op)
         mse_pkg::OP_LBU: begin
            case (addr_ff[1:0])
               2'd0: ld_val = {24'h0, mem_rd_ff[31:24]};
               2'd1: ld_val = {24'h0, mem_rd_ff[23:16]};
               2'd2: ld_val = {24'h0, mem_rd_ff[15:8]};
               default: ld_val = {24'h0, mem_rd_ff[7:0]};
            endcase
         end
         mse_pkg::OP_LHU: ld_val = addr_ff[1] ? {16'h0, mem_rd_ff[15:0]}
                                              : {16'h0, mem_rd_ff[31:16]};
         default: ld_val = mem_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rf_a_ff <= rf[rs];
      rf_b_ff <= rf[rt];
      if (state_ff == S_WB && wr_reg_ff != 5'd0) begin
         rf[wr_reg_ff] <= wr_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      mem_rd_ff <= mem[ex_idx];
      if (state_ff == S_CLEAR) begin
         mem[clr_cnt_ff] <= 32'h0;
      end else if (state_ff == S_EXEC && ex_store) begin
         mem[ex_idx] <= vt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_cnt_ff <= '0;
         pc_ff <= 32'h0;
         hi_ff <= 32'h0;
         lo_ff <= 32'h0;
         halt_ff <= 1'b0;
         rf_vld_ff <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_chan.valid) begin
                  ins_ff <= req_chan.instruction;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               npc_ff <= ex_npc;
               wr_reg_ff <= ex_reg;
               wr_val_ff <= ex_val;
               memw_ff <= ex_store;
               addr_ff <= ex_addr;
               halt_ff <= ex_halt;
               is_div_ff <= ex_div;
               iter_ff <= 5'd0;
               opnd_ff <= ex_div ? mb : ma;
               acc_hi_ff <= 32'h0;
               acc_lo_ff <= ex_div ? ma : mb;
               neg_q_ff <= ex_sgn && (vs[31] != vt[31]);
               neg_r_ff <= ex_sgn && vs[31];
               if (ex_load) begin
                  state_ff <= S_MEM;
               end else if (ex_md && !ex_divzero) begin
                  state_ff <= S_ITER;
               end else begin
                  state_ff <= S_WB;
               end
            end
            S_MEM: begin
               wr_val_ff <= ld_val;
               state_ff <= S_WB;
            end
            S_ITER: begin
               if (is_div_ff) begin
                  acc_hi_ff <= div_ge ? div_d[31:0] : div_t[31:0];
                  acc_lo_ff <= {acc_lo_ff[30:0], div_ge};
               end else begin
                  acc_hi_ff <= mul_sum[32:1];
                  acc_lo_ff <= {mul_sum[0], acc_lo_ff[31:1]};
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == 5'd31) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               if (is_div_ff) begin
                  lo_ff <= neg_q_ff ? -acc_lo_ff : acc_lo_ff;
                  hi_ff <= neg_r_ff ? -acc_hi_ff : acc_hi_ff;
               end else begin
                  hi_ff <= prod_fix[63:32];
                  lo_ff <= prod_fix[31:0];
               end
               state_ff <= S_WB;
            end
            S_WB: begin
               if (!rsp_valid_ff) begin
                  pc_ff <= npc_ff;
                  if (wr_reg_ff != 5'd0) begin
                     rf_vld_ff[wr_reg_ff] <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_npc_ff <= npc_ff;
                  rsp_reg_ff <= wr_reg_ff;
                  rsp_val_ff <= (wr_reg_ff != 5'd0) ? wr_val_ff : 32'h0;
                  rsp_memw_ff <= memw_ff;
                  rsp_halt_ff <= halt_ff;
               end else if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.next_pc = rsp_npc_ff;
   assign rsp_chan.dest_reg = rsp_reg_ff;
   assign rsp_chan.dest_value = rsp_val_ff;
   assign rsp_chan.mem_write = rsp_memw_ff;
   assign rsp_chan.halted = rsp_halt_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request accepted while a response is pending");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.dest_reg == 5'd0) |-> rsp_chan.dest_value == 32'h0)
      else $error("value reported without a register write");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_store_no_reg: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.mem_write) |-> rsp_chan.dest_reg == 5'd0)
      else $error("store reported a register write");

endmodule

// ===== bench/tb_mse_if.sv =====
`timescale 1ns / 1ps
// Note: the RTL already supplies mse_req_if and mse_rsp_if in rtl/mse_if.sv.
// This file holds only the bench types, built on mse_pkg::word_type; it depends on mse_pkg.
package tb_mse_types;

   typedef struct packed {
      mse_pkg::word_type next_pc;
      logic [4:0] dest_reg;
      mse_pkg::word_type dest_value;
      logic mem_write;
      logic halted;
   } exec_result_type;
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mips_subset_execute. A behavioral model of the core
// predicts each response, and directed and random instruction streams drive it.
// Depends on mse_pkg, the RTL interfaces and tb_mse_types.
module tb;

   localparam int MEM_WORDS = 1024;
   localparam int LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   mse_req_if req_chan();
   mse_rsp_if rsp_chan();

   mips_subset_execute #(.MEM_WORDS(MEM_WORDS)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   mse_pkg::word_type gpr [32];
   mse_pkg::word_type pc_m, hi_m, lo_m;
   mse_pkg::word_type dmem [MEM_WORDS];
   logic halt_m;
   tb_mse_types::exec_result_type pending_results [$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0;
   int cycles = 0;
   int n_loads = 0, n_stores = 0, n_muldiv = 0, n_branches = 0;

   function automatic logic [9:0] widx(mse_pkg::word_type a);
      return a[11:2];
   endfunction

   function automatic tb_mse_types::exec_result_type execute_insn(mse_pkg::word_type ins);
      tb_mse_types::exec_result_type r;
      mse_pkg::word_type npc, vs, vt, simm, zimm, addr, w, q, rm, ma, mb;
      logic [63:0] prod;
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sh, wr;
      mse_pkg::word_type wv;
      logic memw;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sh = ins[10:6]; fn = ins[5:0];
      zimm = {16'h0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      gpr[0] = '0;
      vs = gpr[rs]; vt = gpr[rt];
      addr = vs + simm;
      npc = pc_m + 32'd4;
      wr = '0; wv = '0; memw = 1'b0;
      if (halt_m || ins == mse_pkg::HALT_WORD) begin
         halt_m = 1'b1; npc = pc_m;
      end else if (op == mse_pkg::OP_SPECIAL) begin
         case (fn)
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: begin wr = rd; wv = vs + vt; end
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: begin wr = rd; wv = vs - vt; end
            mse_pkg::FN_AND: begin wr = rd; wv = vs & vt; end
            mse_pkg::FN_OR: begin wr = rd; wv = vs | vt; end
            mse_pkg::FN_NOR: begin wr = rd; wv = ~(vs | vt); end
            mse_pkg::FN_SLT: begin wr = rd; wv = {31'd0, $signed(vs) < $signed(vt)}; end
            mse_pkg::FN_SLTU: begin wr = rd; wv = {31'd0, vs < vt}; end
            mse_pkg::FN_SLL: begin wr = rd; wv = vt << sh; end
            mse_pkg::FN_SRL: begin wr = rd; wv = vt >> sh; end
            mse_pkg::FN_SRA: begin wr = rd; wv = 32'($signed(vt) >>> sh); end
            mse_pkg::FN_JR: npc = vs;
            mse_pkg::FN_MULT: begin
               prod = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
               hi_m = prod[63:32]; lo_m = prod[31:0];
            end
            mse_pkg::FN_MULTU: begin
               prod = {32'd0, vs} * {32'd0, vt};
               hi_m = prod[63:32]; lo_m = prod[31:0];
            end
            mse_pkg::FN_DIV: if (vt != 32'd0) begin
               ma = vs[31] ? -vs : vs; mb = vt[31] ? -vt : vt;
               q = ma / mb; rm = ma % mb;
               lo_m = (vs[31] != vt[31]) ? -q : q;
               hi_m = vs[31] ? -rm : rm;
            end
            mse_pkg::FN_DIVU: if (vt != 32'd0) begin lo_m = vs / vt; hi_m = vs % vt; end
            mse_pkg::FN_MFHI: begin wr = rd; wv = hi_m; end
            mse_pkg::FN_MFLO: begin wr = rd; wv = lo_m; end
            default: ;
         endcase
      end else if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL) begin
         if (op == mse_pkg::OP_JAL) begin wr = mse_pkg::LINK_REG; wv = pc_m + 32'd8; end
         npc = ((pc_m + 32'd4) & mse_pkg::JUMP_REGION_MASK) | {4'd0, ins[25:0], 2'b00};
      end else begin
         case (op)
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr = rt; wv = vs + simm; end
            mse_pkg::OP_ANDI: begin wr = rt; wv = vs & zimm; end
            mse_pkg::OP_ORI: begin wr = rt; wv = vs | zimm; end
            mse_pkg::OP_SLTI: begin
               wr = rt; wv = {31'd0, $signed(vs) < $signed(simm)};
            end
            mse_pkg::OP_SLTIU: begin wr = rt; wv = {31'd0, vs < simm}; end
            mse_pkg::OP_LUI: begin wr = rt; wv = zimm << 16; end
            mse_pkg::OP_BEQ: if (vs == vt) npc = npc + (simm << 2);
            mse_pkg::OP_BNE: if (vs != vt) npc = npc + (simm << 2);
            mse_pkg::OP_LW: begin wr = rt; wv = dmem[widx(addr)]; end
            mse_pkg::OP_LBU: begin
               w = dmem[widx(addr)]; wr = rt;
               case (addr[1:0])
                  2'd0: wv = {24'd0, w[31:24]};
                  2'd1: wv = {24'd0, w[23:16]};
                  2'd2: wv = {24'd0, w[15:8]};
                  default: wv = {24'd0, w[7:0]};
               endcase
            end
            mse_pkg::OP_LHU: begin
               w = dmem[widx(addr)]; wr = rt;
               wv = addr[1] ? {16'd0, w[15:0]} : {16'd0, w[31:16]};
            end
            mse_pkg::OP_SW: begin dmem[widx(addr)] = vt; memw = 1'b1; end
            default: ;
         endcase
      end
      if (wr == 5'd0) wv = '0;
      else gpr[wr] = wv;
      pc_m = npc;
      r.next_pc = npc; r.dest_reg = wr; r.dest_value = wv;
      r.mem_write = memw; r.halted = halt_m;
      return r;
   endfunction

   task automatic send_insn(mse_pkg::word_type ins);
      logic [5:0] opc;
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.instruction = ins;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      opc = ins[31:26];
      if (!halt_m && ins != mse_pkg::HALT_WORD) begin
         if (opc == mse_pkg::OP_LW || opc == mse_pkg::OP_LBU || opc == mse_pkg::OP_LHU)
            n_loads++;
         if (opc == mse_pkg::OP_SW) n_stores++;
         if (opc == mse_pkg::OP_BEQ || opc == mse_pkg::OP_BNE) n_branches++;
         if (opc == mse_pkg::OP_SPECIAL && ins[5:3] == 3'b011) n_muldiv++;
      end
      pending_results.push_back(execute_insn(ins));
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   function automatic mse_pkg::word_type rtype(logic [4:0] rs, logic [4:0] rt,
                                               logic [4:0] rd, logic [4:0] sh,
                                               logic [5:0] fn);
      return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic mse_pkg::word_type itype(logic [5:0] op, logic [4:0] rs,
                                               logic [4:0] rt, logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic mse_pkg::word_type random_insn();
      logic [5:0] ops [16];
      logic [5:0] fns [19];
      logic [4:0] rs, rt, rd;
      logic [15:0] imm;
      logic [5:0] op;
      int k;
      ops = '{mse_pkg::OP_SPECIAL, mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_BEQ,
              mse_pkg::OP_BNE, mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTI,
              mse_pkg::OP_SLTIU, mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_LUI,
              mse_pkg::OP_LW, mse_pkg::OP_LBU, mse_pkg::OP_LHU, mse_pkg::OP_SW};
      fns = '{mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA, mse_pkg::FN_JR,
              mse_pkg::FN_MFHI, mse_pkg::FN_MFLO, mse_pkg::FN_MULT, mse_pkg::FN_MULTU,
              mse_pkg::FN_DIV, mse_pkg::FN_DIVU, mse_pkg::FN_ADD, mse_pkg::FN_ADDU,
              mse_pkg::FN_SUB, mse_pkg::FN_SUBU, mse_pkg::FN_AND, mse_pkg::FN_OR,
              mse_pkg::FN_NOR, mse_pkg::FN_SLT, mse_pkg::FN_SLTU};
      rs = 5'($urandom_range(7)); rt = 5'($urandom_range(7)); rd = 5'($urandom_range(7));
      if ($urandom_range(9) == 0) rd = 5'($urandom);
      if ($urandom_range(9) == 0) rs = 5'($urandom);
      if ($urandom_range(9) == 0) rt = 5'($urandom);
      imm = 16'($urandom);
      k = int'($urandom_range(99));
      if (k < 3) return $urandom;
      if (k < 45) begin
         if ($urandom_range(7) == 0)
            return rtype(rs, rt, rd, 5'($urandom),
                         $urandom_range(1) ? mse_pkg::FN_MULT : mse_pkg::FN_DIV);
         return rtype(rs, rt, rd, 5'($urandom), fns[$urandom_range(18)]);
      end
      op = ops[$urandom_range(1, 15)];
      if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL) return {op, 26'($urandom)};
      if (op == mse_pkg::OP_LW || op == mse_pkg::OP_LBU || op == mse_pkg::OP_LHU ||
          op == mse_pkg::OP_SW)
         return itype(op, $urandom_range(1) ? 5'd0 : rs, rt,
                      $urandom_range(1) ? 16'($urandom_range(255)) : imm);
      if (op == mse_pkg::OP_BEQ || op == mse_pkg::OP_BNE)
         return itype(op, rs, rt, 16'($signed($urandom_range(8)) - 4));
      return itype(op, rs, rt, imm);
   endfunction

   always @(posedge clock) begin
      tb_mse_types::exec_result_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.next_pc = rsp_chan.next_pc; got.dest_reg = rsp_chan.dest_reg;
         got.dest_value = rsp_chan.dest_value; got.mem_write = rsp_chan.mem_write;
         got.halted = rsp_chan.halted;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: expected no transaction actual %h", $time, got);
         end else begin
            want = pending_results.pop_front();
            if (got.next_pc !== want.next_pc)
               $display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
            if (got.dest_reg !== want.dest_reg)
               $display("%0t: dest_reg expected %0d actual %0d", $time, want.dest_reg,
                        got.dest_reg);
            if (got.dest_value !== want.dest_value)
               $display("%0t: dest_value expected %h actual %h", $time, want.dest_value,
                        got.dest_value);
            if (got.mem_write !== want.mem_write)
               $display("%0t: mem_write expected %b actual %b", $time, want.mem_write,
                        got.mem_write);
            if (got.halted !== want.halted)
               $display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
            if (got !== want) errors++;
         end
      end
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_chan.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

   typedef struct {
      mse_pkg::word_type insn;
      logic check_known;
      tb_mse_types::exec_result_type known;
   } stim_row_type;

   stim_row_type directed [$];
   tb_mse_types::exec_result_type p;

   task automatic add_row(mse_pkg::word_type ins, logic known_ok,
                          tb_mse_types::exec_result_type kv);
      stim_row_type r;
      r.insn = ins; r.check_known = known_ok; r.known = kv;
      directed.push_back(r);
   endtask

   initial begin
      int ph;
      req_chan.valid = 1'b0;
      req_chan.instruction = '0;
      rsp_chan.ready = 1'b1;
      p = '0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc_m = '0; hi_m = '0; lo_m = '0; halt_m = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(itype(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF), 1'b1,
              '{32'd4, 5'd1, 32'hFFFF0000, 1'b0, 1'b0});
      add_row(itype(mse_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF), 1'b1,
              '{32'd8, 5'd1, 32'hFFFFFFFF, 1'b0, 1'b0});
      add_row(itype(mse_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000), 1'b1,
              '{32'd12, 5'd2, 32'hFFFF8000, 1'b0, 1'b0});
      add_row(itype(mse_pkg::OP_ADDIU, 5'd0, 5'd0, 16'h1234), 1'b1,
              '{32'd16, 5'd0, 32'd0, 1'b0, 1'b0});
      add_row(itype(mse_pkg::OP_LUI, 5'd0, 5'd3, 16'h8000), 1'b1,
              '{32'd20, 5'd3, 32'h80000000, 1'b0, 1'b0});
      add_row(rtype(5'd3, 5'd1, 5'd4, 5'd0, mse_pkg::FN_ADD), 1'b0, p);
      add_row(rtype(5'd3, 5'd1, 5'd5, 5'd0, mse_pkg::FN_SUB), 1'b0, p);
      add_row(rtype(5'd1, 5'd2, 5'd6, 5'd0, mse_pkg::FN_NOR), 1'b0, p);
      add_row(rtype(5'd3, 5'd0, 5'd7, 5'd31, mse_pkg::FN_SRA), 1'b0, p);
      add_row(rtype(5'd0, 5'd3, 5'd7, 5'd31, mse_pkg::FN_SRL), 1'b0, p);
      add_row(rtype(5'd0, 5'd1, 5'd7, 5'd31, mse_pkg::FN_SLL), 1'b0, p);
      add_row(rtype(5'd3, 5'd1, 5'd8, 5'd0, mse_pkg::FN_SLT), 1'b0, p);
      add_row(rtype(5'd3, 5'd1, 5'd8, 5'd0, mse_pkg::FN_SLTU), 1'b0, p);
      add_row(itype(mse_pkg::OP_SLTIU, 5'd0, 5'd9, 16'hFFFF), 1'b0, p);
      add_row(itype(mse_pkg::OP_SLTI, 5'd3, 5'd9, 16'h0001), 1'b0, p);
      add_row(rtype(5'd3, 5'd1, 5'd0, 5'd0, mse_pkg::FN_DIV), 1'b0, p);
      add_row(rtype(5'd0, 5'd0, 5'd10, 5'd0, mse_pkg::FN_MFLO), 1'b0, p);
      add_row(rtype(5'd3, 5'd0, 5'd0, 5'd0, mse_pkg::FN_DIVU), 1'b0, p);
      add_row(rtype(5'd1, 5'd1, 5'd0, 5'd0, mse_pkg::FN_MULT), 1'b0, p);
      add_row(rtype(5'd0, 5'd0, 5'd11, 5'd0, mse_pkg::FN_MFHI), 1'b0, p);
      add_row(itype(mse_pkg::OP_SW, 5'd0, 5'd3, 16'hFFFC), 1'b0, p);
      add_row(itype(mse_pkg::OP_LBU, 5'd0, 5'd12, 16'hFFFC), 1'b0, p);
      add_row(itype(mse_pkg::OP_LHU, 5'd0, 5'd12, 16'hFFFE), 1'b0, p);
      add_row(itype(mse_pkg::OP_ANDI, 5'd1, 5'd13, 16'h8001), 1'b0, p);
      add_row({mse_pkg::OP_JAL, 26'h3FFFFFF}, 1'b0, p);

      foreach (directed[i]) begin
         send_insn(directed[i].insn);
         if (directed[i].check_known && pending_results[$] !== directed[i].known) begin
            errors++;
            $display("%0t: table row %0d expected %h actual %h", $time, i,
                     directed[i].known, pending_results[$]);
         end
      end

      for (ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 24) : 0;
         recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 24) : 0;
         repeat (490) send_insn(random_insn());
         while (pending_results.size() != 0) @(negedge clock);
      end

      send_idle = 0; recv_stall = 0;
      send_insn(mse_pkg::HALT_WORD);
      repeat (5) send_insn($urandom);

      while (pending_results.size() != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d loads, %0d stores, %0d branches, %0d multiply/divide ops,",
               n_loads, n_stores, n_branches, n_muldiv);
      $display("then halt with ignored words, under four idling phases.");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
